[rtl/settings_pair_block_parser_assert.svh]
// Assertion helpers for the settings pair block parser.
`ifndef SETTINGS_PAIR_BLOCK_PARSER_ASSERT_SVH
`define SETTINGS_PAIR_BLOCK_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPBP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/spbp_pkg.sv]
package spbp_pkg;

   // Block layout: 4-byte count, then 8-byte records.
   localparam int unsigned COUNT_BYTES  = 4;
   localparam int unsigned RECORD_BYTES = 8;
   localparam int unsigned POS_W        = 3;
   localparam int unsigned SHIFT_W      = 56;

   localparam logic [POS_W-1:0] COUNT_LAST_POS  = POS_W'(COUNT_BYTES - 1);
   localparam logic [POS_W-1:0] RECORD_LAST_POS = POS_W'(RECORD_BYTES - 1);

   // Result queue; the depth must be a power of two and at least two.
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_LVL_W = RSP_PTR_W + 1;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PAIRS  = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_PAIR  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] pair_id;
      logic [7:0]  pair_flag;
      logic [31:0] pair_value;
      logic        block_done;
      logic        last;
   } rsp_entry_type;

   // Up to two results produced by one accepted byte, in order.
   typedef struct packed {
      logic          first_valid;
      rsp_entry_type first;
      logic          second_valid;
      rsp_entry_type second;
   } push_type;

endpackage

[rtl/spbp_req_if.sv]
interface spbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_end;
   logic       new_block;

   modport source (output valid, output data_byte, output chunk_end, output new_block,
                   input ready);
   modport sink (input valid, input data_byte, input chunk_end, input new_block,
                 output ready);
endinterface

[rtl/spbp_rsp_if.sv]
interface spbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [23:0] pair_id;
   logic [7:0]  pair_flag;
   logic [31:0] pair_value;
   logic        block_done;
   logic        last;

   modport source (output valid, output status, output pair_id, output pair_flag,
                   output pair_value, output block_done, output last, input ready);
   modport sink (input valid, input status, input pair_id, input pair_flag,
                 input pair_value, input block_done, input last, output ready);
endinterface

[rtl/spbp_parser.sv]
module spbp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               chunk_end,
   input  logic               new_block,
   input  logic               version_two,
   output spbp_pkg::push_type push
);

   spbp_pkg::phase_type                 phase_ff, phase_in;
   logic [spbp_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [31:0]                         count_ff, count_in;
   logic [31:0]                         done_ff, done_in;
   logic [spbp_pkg::SHIFT_W-1:0]        shift_ff, shift_in;

   spbp_pkg::phase_type                 ph;
   logic [spbp_pkg::POS_W-1:0]          pos;
   logic [31:0]                         cnt;
   logic [31:0]                         pd;
   logic [spbp_pkg::SHIFT_W-1:0]        sh;
   logic [63:0]                         word;
   logic [31:0]                         pairs_next;
   logic                                finished;
   logic                                byte_valid;
   spbp_pkg::rsp_entry_type             byte_res;
   logic                                short_valid;
   spbp_pkg::rsp_entry_type             short_res;

   // Parse one byte: restart first, then header or record assembly, then chunk end.
   always_comb begin
      ph  = new_block ? spbp_pkg::PH_HEADER : phase_ff;
      pos = new_block ? '0 : pos_ff;
      cnt = new_block ? '0 : count_ff;
      pd  = new_block ? '0 : done_ff;
      sh  = new_block ? '0 : shift_ff;

      word       = {sh, data_byte};
      pairs_next = pd + 32'd1;
      finished   = (pairs_next >= cnt);

      phase_in   = ph;
      pos_in     = pos;
      count_in   = cnt;
      done_in    = pd;
      shift_in   = sh;
      byte_valid = 1'b0;
      byte_res   = '0;

      unique case (ph)
         spbp_pkg::PH_HEADER: begin
            if (pos >= spbp_pkg::COUNT_LAST_POS) begin
               count_in = word[31:0];
               pos_in   = '0;
               shift_in = '0;
               done_in  = '0;
               if (word[31:0] == 32'd0) begin
                  phase_in            = spbp_pkg::PH_DONE;
                  byte_valid          = 1'b1;
                  byte_res.status     = spbp_pkg::ST_EMPTY;
                  byte_res.block_done = 1'b1;
               end else begin
                  phase_in = spbp_pkg::PH_PAIRS;
               end
            end else begin
               shift_in = word[spbp_pkg::SHIFT_W-1:0];
               pos_in   = pos + spbp_pkg::POS_W'(1);
            end
         end
         spbp_pkg::PH_PAIRS: begin
            if (pos >= spbp_pkg::RECORD_LAST_POS) begin
               byte_valid          = 1'b1;
               byte_res.status     = spbp_pkg::ST_PAIR;
               byte_res.pair_value = word[31:0];
               byte_res.block_done = finished;
               // Version 2 puts a little-endian id ahead of the flag byte.
               if (version_two) begin
                  byte_res.pair_id   = {word[47:40], word[55:48], word[63:56]};
                  byte_res.pair_flag = word[39:32];
               end else begin
                  byte_res.pair_id   = word[55:32];
                  byte_res.pair_flag = word[63:56];
               end
               done_in  = pairs_next;
               pos_in   = '0;
               shift_in = '0;
               if (finished) begin
                  phase_in = spbp_pkg::PH_DONE;
               end
            end else begin
               shift_in = word[spbp_pkg::SHIFT_W-1:0];
               pos_in   = pos + spbp_pkg::POS_W'(1);
            end
         end
         default: begin
            // Completed block, or the unused phase code: bytes are ignored.
         end
      endcase

      // A chunk ending while the block is still open drops the partial field.
      short_valid = chunk_end &&
                    (phase_in == spbp_pkg::PH_HEADER || phase_in == spbp_pkg::PH_PAIRS);
      short_res        = '0;
      short_res.status = spbp_pkg::ST_SHORT;
      short_res.last   = 1'b1;
      if (short_valid) begin
         pos_in   = '0;
         shift_in = '0;
      end
      byte_res.last = !short_valid;

      // Order the results: the byte's own result first, then the short mark.
      push.first_valid  = accept && (byte_valid || short_valid);
      push.first        = byte_valid ? byte_res : short_res;
      push.second_valid = accept && byte_valid && short_valid;
      push.second       = short_res;
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spbp_pkg::PH_HEADER;
         pos_ff   <= '0;
         count_ff <= '0;
         done_ff  <= '0;
         shift_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         shift_ff <= shift_in;
      end
   end

endmodule

[rtl/spbp_rsp_fifo.sv]
module spbp_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  spbp_pkg::push_type                push,
   output logic                              space_ok,
   output logic [spbp_pkg::RSP_LVL_W-1:0]    level,
   spbp_rsp_if.source                        rsp_chan
);

   spbp_pkg::rsp_entry_type                  entry_ff [spbp_pkg::RSP_DEPTH];
   logic [spbp_pkg::RSP_PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [spbp_pkg::RSP_PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [spbp_pkg::RSP_LVL_W-1:0]           level_ff, level_in;
   logic [1:0]                               n_push;
   logic                                     pop;
   spbp_pkg::rsp_entry_type                  head;

   // Pointer and fill level bookkeeping; up to two pushes and one pop per cycle.
   always_comb begin
      n_push    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      pop       = rsp_chan.valid && rsp_chan.ready;
      wr_ptr_in = wr_ptr_ff + spbp_pkg::RSP_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + spbp_pkg::RSP_PTR_W'(pop);
      level_in  = level_ff + spbp_pkg::RSP_LVL_W'(n_push) - spbp_pkg::RSP_LVL_W'(pop);
      space_ok  = (level_ff <= spbp_pkg::RSP_LVL_W'(spbp_pkg::RSP_DEPTH - 2));
      level     = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_ff + spbp_pkg::RSP_PTR_W'(1)] <= push.second;
      end
   end

   // Head of the queue drives the result channel.
   assign head                = entry_ff[rd_ptr_ff];
   assign rsp_chan.valid      = (level_ff != '0);
   assign rsp_chan.status     = head.status;
   assign rsp_chan.pair_id    = head.pair_id;
   assign rsp_chan.pair_flag  = head.pair_flag;
   assign rsp_chan.pair_value = head.pair_value;
   assign rsp_chan.block_done = head.block_done;
   assign rsp_chan.last       = head.last;

endmodule

[rtl/settings_pair_block_parser.sv]
// Channel    Dir  Payload                                                Accepted
// req_chan   in   data_byte, chunk_end, new_block                        valid && ready
// rsp_chan   out  status, pair_id, pair_flag, pair_value, block_done,    valid && ready
//                 last
// csr        in   csr_wr_data (version two mode)                         csr_wr_en
//
// One byte is accepted per cycle; its results are registered in a four-entry result
// queue whose head drives rsp_chan. The result port drains one transaction per cycle
// while rsp_chan.ready is high, so a byte that yields a pair and an insufficient-data
// mark takes two transactions. req_chan.ready drops while fewer than two queue entries
// are free. Reset is synchronous and clears parse state, the queue and the mode.
`include "settings_pair_block_parser_assert.svh"

module settings_pair_block_parser (
   input  logic        clock,
   input  logic        reset,
   spbp_req_if.sink    req_chan,
   spbp_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                                  version_two_ff;
   logic                                  accept;
   logic                                  space_ok;
   logic [spbp_pkg::RSP_LVL_W-1:0]        fifo_level;
   spbp_pkg::push_type                    push;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         version_two_ff <= 1'b0;
      end else if (csr_wr_en) begin
         version_two_ff <= csr_wr_data;
      end
   end

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;

   spbp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_chan.data_byte),
      .chunk_end   (req_chan.chunk_end),
      .new_block   (req_chan.new_block),
      .version_two (version_two_ff),
      .push        (push)
   );

   spbp_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .level    (fifo_level),
      .rsp_chan (rsp_chan)
   );

   `SPBP_ASSERT_SAME(a_push_order, push.second_valid, push.first_valid, "second result without first")
   `SPBP_ASSERT_SAME(a_second_short, push.second_valid, push.second.status == spbp_pkg::ST_SHORT && !push.second.block_done, "second result is not insufficient data")
   `SPBP_ASSERT_SAME(a_single_last, push.first_valid && !push.second_valid, push.first.last, "single result lacks last mark")
   `SPBP_ASSERT_NEXT(a_level_bound, req_chan.valid && req_chan.ready, fifo_level <= spbp_pkg::RSP_LVL_W'(spbp_pkg::RSP_DEPTH), "result queue overflow")

endmodule
